>>> sv/hid3_pkg.sv
// Shared types, rotation tables and widths for the 3D Hilbert index pipeline.
`default_nettype none
package hid3_pkg;

  localparam int LEVELS_W = 5;
  localparam int CFG_W    = 8;
  localparam int CODE_OUT_W = 63;
  localparam int OUT_TDATA_W = 64;

  // Eight 3-bit entries, entry 0 in the low bits.
  typedef logic [7:0][2:0] hid3_rot_t;

  // Starting octant order, entries 7 down to 0.
  localparam hid3_rot_t GEO_ORDER = {3'd5, 3'd6, 3'd2, 3'd1, 3'd4, 3'd7, 3'd3, 3'd0};

  // Transition rows selected by the emitted digit.
  localparam hid3_rot_t TRANS [8] = '{
    {3'd3, 3'd4, 3'd5, 3'd2, 3'd1, 3'd6, 3'd7, 3'd0},
    {3'd1, 3'd2, 3'd5, 3'd6, 3'd7, 3'd4, 3'd3, 3'd0},
    {3'd1, 3'd2, 3'd5, 3'd6, 3'd7, 3'd4, 3'd3, 3'd0},
    {3'd5, 3'd4, 3'd7, 3'd6, 3'd1, 3'd0, 3'd3, 3'd2},
    {3'd5, 3'd4, 3'd7, 3'd6, 3'd1, 3'd0, 3'd3, 3'd2},
    {3'd7, 3'd4, 3'd3, 3'd0, 3'd1, 3'd2, 3'd5, 3'd6},
    {3'd7, 3'd4, 3'd3, 3'd0, 3'd1, 3'd2, 3'd5, 3'd6},
    {3'd7, 3'd0, 3'd1, 3'd6, 3'd5, 3'd2, 3'd3, 3'd4}
  };

  function automatic hid3_rot_t hid3_rotate(input logic [2:0] digit, input hid3_rot_t rot);
    hid3_rot_t res;
    hid3_rot_t row;
    row = TRANS[digit];
    for (int i = 0; i < 8; i++) begin
      res[i] = row[rot[i]];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

>>> sv/hilbert_index_3d.sv
// One register per level between input beat and result beat; each stage holds under stall.
// Throughput: one beat per cycle unless stalled; each level stage has its own valid.
// Bubbles collapse: a stage takes a new beat whenever it is empty or its successor advances.
// Reset (rst_n low, synchronous) empties every stage and sets levels to 21.
// Levels above MAX_LEVELS act as MAX_LEVELS; zero levels give a zero code.
`default_nettype none
module hilbert_index_3d
  import hid3_pkg::*;
#(
  parameter int MAX_LEVELS  = 21,
  parameter int COORD_WIDTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_tvalid,
  output logic                                        in_tready,
  // x_coord, y_coord, z_coord from bit 0 up, zero padding to whole bytes
  input  wire logic [((3*COORD_WIDTH+7)/8)*8-1:0]     in_tdata,
  output logic                                        out_tvalid,
  input  wire logic                                   out_tready,
  // curve_code from bit 0 up, one zero pad bit
  output logic [OUT_TDATA_W-1:0]                      out_tdata,
  input  wire logic                                   cfg_tvalid,
  output logic                                        cfg_tready,
  // levels in bits 4:0, upper bits ignored
  input  wire logic [CFG_W-1:0]                       cfg_tdata
);

  localparam int CODE_W = 3 * MAX_LEVELS;
  localparam logic [LEVELS_W-1:0] MAX_LEV = LEVELS_W'(MAX_LEVELS);

  logic [LEVELS_W-1:0] levels_r;
  logic [LEVELS_W-1:0] levels_eff;

  logic                   vld [0:MAX_LEVELS];
  logic                   rdy [0:MAX_LEVELS];
  logic [COORD_WIDTH-1:0] xs [0:MAX_LEVELS];
  logic [COORD_WIDTH-1:0] ys [0:MAX_LEVELS];
  logic [COORD_WIDTH-1:0] zs [0:MAX_LEVELS];
  logic [CODE_W-1:0]      codes [0:MAX_LEVELS];
  hid3_rot_t              rots [0:MAX_LEVELS];

  assign cfg_tready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      levels_r <= LEVELS_W'(21);
    end else if (cfg_tvalid && cfg_tready) begin
      levels_r <= cfg_tdata[LEVELS_W-1:0];
    end
  end

  assign levels_eff = (levels_r > MAX_LEV) ? MAX_LEV : levels_r;

  assign vld[0]   = in_tvalid;
  assign in_tready = rdy[0];
  assign xs[0]    = in_tdata[COORD_WIDTH-1:0];
  assign ys[0]    = in_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
  assign zs[0]    = in_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];
  assign codes[0] = '0;
  assign rots[0]  = GEO_ORDER;

  for (genvar g = 0; g < MAX_LEVELS; g++) begin : g_lvl
    hid3_stage #(
      .COORD_WIDTH(COORD_WIDTH),
      .CODE_W     (CODE_W)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .active   (levels_eff > LEVELS_W'(g)),
      .in_valid (vld[g]),
      .in_ready (rdy[g]),
      .in_x     (xs[g]),
      .in_y     (ys[g]),
      .in_z     (zs[g]),
      .in_code  (codes[g]),
      .in_rot   (rots[g]),
      .out_valid(vld[g+1]),
      .out_ready(rdy[g+1]),
      .out_x    (xs[g+1]),
      .out_y    (ys[g+1]),
      .out_z    (zs[g+1]),
      .out_code (codes[g+1]),
      .out_rot  (rots[g+1])
    );
  end

  assign rdy[MAX_LEVELS] = out_tready;
  assign out_tvalid      = vld[MAX_LEVELS];
  assign out_tdata       = OUT_TDATA_W'(codes[MAX_LEVELS]);

  // a ready sink must never back-pressure the source
  a_ready_path: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output is ready");

  a_reset_empty: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> !out_tvalid)
    else $error("result beat right after reset");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[OUT_TDATA_W-1])
    else $error("pad bit of result set");

  a_cfg_always: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_tvalid && $past(rst_n)) |=> (levels_r == $past(cfg_tdata[LEVELS_W-1:0])))
    else $error("levels write lost");

endmodule
`default_nettype wire

>>> sv/hid3_stage.sv
// One level, if active: picks the octant, appends a digit, rewrites the rotation.
`default_nettype none
module hid3_stage
  import hid3_pkg::*;
#(
  parameter int COORD_WIDTH = 64,
  parameter int CODE_W      = 63
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   active,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [COORD_WIDTH-1:0] in_x,
  input  wire logic [COORD_WIDTH-1:0] in_y,
  input  wire logic [COORD_WIDTH-1:0] in_z,
  input  wire logic [CODE_W-1:0]      in_code,
  input  wire hid3_rot_t              in_rot,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [COORD_WIDTH-1:0]      out_x,
  output logic [COORD_WIDTH-1:0]      out_y,
  output logic [COORD_WIDTH-1:0]      out_z,
  output logic [CODE_W-1:0]           out_code,
  output hid3_rot_t                   out_rot
);

  logic                   valid_r;
  logic [COORD_WIDTH-1:0] x_r, y_r, z_r, x_nxt, y_nxt, z_nxt;
  logic [CODE_W-1:0]      code_r, code_nxt;
  hid3_rot_t              rot_r, rot_nxt;
  logic [2:0]             word;
  logic [2:0]             digit;
  logic                   load;

  assign in_ready = !valid_r || out_ready;
  assign load     = in_valid && in_ready;

  always_comb begin
    word  = {in_z[COORD_WIDTH-1], in_y[COORD_WIDTH-1], in_x[COORD_WIDTH-1]};
    digit = in_rot[word];
    if (active) begin
      // shift in zeros so levels past the coordinate width read as zero
      x_nxt    = in_x << 1;
      y_nxt    = in_y << 1;
      z_nxt    = in_z << 1;
      code_nxt = (in_code << 3) | CODE_W'(digit);
      rot_nxt  = hid3_rotate(digit, in_rot);
    end else begin
      x_nxt    = in_x;
      y_nxt    = in_y;
      z_nxt    = in_z;
      code_nxt = in_code;
      rot_nxt  = in_rot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      code_r <= code_nxt;
      rot_r  <= rot_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_z     = z_r;
  assign out_code  = code_r;
  assign out_rot   = rot_r;

endmodule
`default_nettype wire
